[rtl/core/ipv4_encap_pkg.sv]
// ipv4_encap_pkg: shared types and constants for the ipv4 header encapsulator
// no dependencies; imported by the top level and the checker
`timescale 1ns / 1ps

package ipv4_encap_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PROTOCOL       = 3'd0;
    localparam t_cfg_idx CFG_SOURCE_ADDR    = 3'd1;
    localparam t_cfg_idx CFG_FIXED_DST_ADDR = 3'd2;
    localparam t_cfg_idx CFG_TYPE_OF_SVC    = 3'd3;
    localparam t_cfg_idx CFG_TIME_TO_LIVE   = 3'd4;
    localparam t_cfg_idx CFG_DONT_FRAGMENT  = 3'd5;
    localparam t_cfg_idx CFG_NEXT_HOP_MODE  = 3'd6;

    localparam int unsigned CFG_DATA_W = 32;

    // header constants
    localparam logic [7:0]  VER_IHL        = 8'h45;
    localparam logic [15:0] HDR_BYTES      = 16'd20;
    localparam logic [15:0] MAX_TOTAL      = 16'hFFFF;
    localparam logic [15:0] DF_WORD        = 16'h4000;
    localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
    localparam logic [7:0]  TTL_AT_RESET   = 8'd250;

    // configuration register file
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] fixed_dst_addr;
        logic [7:0]  type_of_service;
        logic [7:0]  time_to_live;
        logic        dont_fragment;
        logic        next_hop_mode;
    } t_cfg;

    // one packet descriptor
    typedef struct packed {
        logic [15:0] payload_length;
        logic [31:0] next_hop_id;
        logic [31:0] lookup_addr;
    } t_in_item;

endpackage

[rtl/core/ipv4_encap_in_if.sv]
// ipv4_encap_in_if: valid/ready channel carrying one packet descriptor
// depends on nothing; payload widths follow the descriptor fields
`timescale 1ns / 1ps

interface ipv4_encap_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [31:0] next_hop_id;
    logic [31:0] lookup_addr;

    modport source (output valid, payload_length, next_hop_id, lookup_addr, input ready);
    modport sink   (input valid, payload_length, next_hop_id, lookup_addr, output ready);
endinterface

[rtl/core/ipv4_encap_out_if.sv]
// ipv4_encap_out_if: valid/ready channel carrying one header result
// depends on nothing; payload widths follow the result fields
`timescale 1ns / 1ps

interface ipv4_encap_out_if;
    logic        valid;
    logic        ready;
    logic        drop;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [31:0] dst_addr;
    logic [15:0] header_checksum;

    modport source (output valid, drop, total_length, ident, dst_addr, header_checksum,
                    input ready);
    modport sink   (input valid, drop, total_length, ident, dst_addr, header_checksum,
                    output ready);
endinterface

[rtl/core/ipv4_header_encapsulator.sv]
// ipv4_header_encapsulator: builds the variable fields of a 20-byte ipv4 header per packet
// depends on ipv4_encap_pkg, ipv4_encap_in_if and ipv4_encap_out_if
//
//   channel   dir  handshake      payload
//   i_in      in   valid/ready    payload_length, next_hop_id, lookup_addr
//   o_out     out  valid/ready    drop, total_length, ident, dst_addr, header_checksum
//   cfg       in   i_cfg_we       i_cfg_idx, i_cfg_wdata (no read-back)
//
// one descriptor per cycle sustained while the result side does not stall; a result passes from its
// input transfer through the input register, then the header logic, into the result register
// the header checksum adder tree and total length saturation sit between those registers
// a stalled result holds in the result register while the input register keeps one more item
// synchronous active-low reset empties both stages, clears the ident counter and loads
// register defaults (ttl 250, all else zero)
`timescale 1ns / 1ps

module ipv4_header_encapsulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  ipv4_encap_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [ipv4_encap_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    ipv4_encap_in_if.sink                     i_in,
    ipv4_encap_out_if.source                  o_out
);
    import ipv4_encap_pkg::*;

    t_cfg        r_cfg;
    logic        r_s1_vld;
    t_in_item    r_s1_item;
    logic [15:0] r_ident_cnt;

    logic        r_out_vld;
    logic        r_out_drop;
    logic [15:0] r_out_total;
    logic [15:0] r_out_ident;
    logic [31:0] r_out_dst;
    logic [15:0] r_out_csum;

    logic        out_free;
    logic        s1_move;
    logic        in_xfer;
    logic        nh_fail;
    logic [31:0] dst_sel;
    logic [16:0] total_raw;
    logic [15:0] total_sat;
    logic [15:0] hdr_w0;
    logic [15:0] hdr_w3;
    logic [15:0] hdr_w4;
    logic [19:0] csum_acc;
    logic [16:0] csum_fold1;
    logic [15:0] csum_fold2;
    logic [15:0] n_csum;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{8'd0, 32'd0, 32'd0, 8'd0, TTL_AT_RESET, 1'b0, 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROTOCOL:       r_cfg.protocol        <= i_cfg_wdata[7:0];
                CFG_SOURCE_ADDR:    r_cfg.source_addr     <= i_cfg_wdata[31:0];
                CFG_FIXED_DST_ADDR: r_cfg.fixed_dst_addr  <= i_cfg_wdata[31:0];
                CFG_TYPE_OF_SVC:    r_cfg.type_of_service <= i_cfg_wdata[7:0];
                CFG_TIME_TO_LIVE:   r_cfg.time_to_live    <= i_cfg_wdata[7:0];
                CFG_DONT_FRAGMENT:  r_cfg.dont_fragment   <= i_cfg_wdata[0];
                CFG_NEXT_HOP_MODE:  r_cfg.next_hop_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign out_free   = !r_out_vld || o_out.ready;
    assign s1_move    = r_s1_vld && out_free;
    assign i_in.ready = !r_s1_vld || out_free;
    assign in_xfer    = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.payload_length <= i_in.payload_length;
            r_s1_item.next_hop_id    <= i_in.next_hop_id;
            r_s1_item.lookup_addr    <= i_in.lookup_addr;
        end
    end

    // destination select and lookup failure
    always_comb begin
        nh_fail = 1'b0;
        dst_sel = r_cfg.fixed_dst_addr;
        if (r_cfg.next_hop_mode) begin
            if (r_s1_item.next_hop_id == '0) begin
                dst_sel = BROADCAST_ADDR;
            end else if (r_s1_item.lookup_addr != '0) begin
                dst_sel = r_s1_item.lookup_addr;
            end else begin
                nh_fail = 1'b1;
            end
        end
    end

    // total length, saturated at the field maximum
    assign total_raw = {1'b0, r_s1_item.payload_length} + {1'b0, HDR_BYTES};
    assign total_sat = total_raw[16] ? MAX_TOTAL : total_raw[15:0];

    // ones-complement checksum over the nine header words other than the checksum field
    assign hdr_w0 = {VER_IHL, r_cfg.type_of_service};
    assign hdr_w3 = r_cfg.dont_fragment ? DF_WORD : 16'h0000;
    assign hdr_w4 = {r_cfg.time_to_live, r_cfg.protocol};

    always_comb begin
        csum_acc = {4'h0, hdr_w0}
                 + {4'h0, total_sat}
                 + {4'h0, r_ident_cnt}
                 + {4'h0, hdr_w3}
                 + {4'h0, hdr_w4}
                 + {4'h0, r_cfg.source_addr[31:16]}
                 + {4'h0, r_cfg.source_addr[15:0]}
                 + {4'h0, dst_sel[31:16]}
                 + {4'h0, dst_sel[15:0]};
        csum_fold1 = {1'b0, csum_acc[15:0]} + {13'h0000, csum_acc[19:16]};
        csum_fold2 = csum_fold1[15:0] + {15'h0000, csum_fold1[16]};
        n_csum     = ~csum_fold2;
    end

    // ident counter advances only for headers that are emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident_cnt <= '0;
        end else if (s1_move && !nh_fail) begin
            r_ident_cnt <= r_ident_cnt + 16'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_drop <= nh_fail;
            if (nh_fail) begin
                r_out_total <= '0;
                r_out_ident <= '0;
                r_out_dst   <= '0;
                r_out_csum  <= '0;
            end else begin
                r_out_total <= total_sat;
                r_out_ident <= r_ident_cnt;
                r_out_dst   <= dst_sel;
                r_out_csum  <= n_csum;
            end
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.drop            = r_out_drop;
    assign o_out.total_length    = r_out_total;
    assign o_out.ident           = r_out_ident;
    assign o_out.dst_addr        = r_out_dst;
    assign o_out.header_checksum = r_out_csum;

endmodule

[rtl/core/ipv4_encap_chk.sv]
// ipv4_encap_chk: port-level checks on the ipv4 header encapsulator over time
// depends on ipv4_encap_pkg; bound to ipv4_header_encapsulator below
`timescale 1ns / 1ps

module ipv4_encap_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_drop,
    input logic [15:0] i_out_total_length,
    input logic [15:0] i_out_ident,
    input logic [31:0] i_out_dst_addr,
    input logic [15:0] i_out_header_checksum
);
    import ipv4_encap_pkg::*;

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_drop)
            && $stable(i_out_total_length) && $stable(i_out_ident)
            && $stable(i_out_dst_addr) && $stable(i_out_header_checksum))
        else $error("stalled result changed");

    // a dropped packet carries all-zero header fields
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_drop |-> i_out_total_length == '0 && i_out_ident == '0
            && i_out_dst_addr == '0 && i_out_header_checksum == '0)
        else $error("dropped result has nonzero fields");

    // an emitted header always includes its own 20 bytes
    a_min_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_drop |-> i_out_total_length >= HDR_BYTES)
        else $error("total length below header size");

    // with the result register empty the input side never stalls
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind ipv4_header_encapsulator ipv4_encap_chk u_ipv4_encap_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_in_valid            (i_in.valid),
    .i_in_ready            (i_in.ready),
    .i_out_valid           (o_out.valid),
    .i_out_ready           (o_out.ready),
    .i_out_drop            (o_out.drop),
    .i_out_total_length    (o_out.total_length),
    .i_out_ident           (o_out.ident),
    .i_out_dst_addr        (o_out.dst_addr),
    .i_out_header_checksum (o_out.header_checksum)
);
